// ----- sv/two_level_name_directory_unit_defines.svh -----
// Assertion macros shared by the two-level name directory RTL.
`ifndef TWO_LEVEL_NAME_DIRECTORY_UNIT_DEFINES_SVH
`define TWO_LEVEL_NAME_DIRECTORY_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define TLND_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define TLND_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define TLND_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tlnd_pkg.sv -----
// Types, constants and helpers of the two-level name directory.
`timescale 1ns / 1ps
`default_nettype none

package tlnd_pkg;

    // Table geometry.
    localparam int MAX_DIRS       = 8;
    localparam int FILES_PER_DIR  = 8;
    localparam int DEF_NAME_BYTES = 8;

    // Field widths on the streams.
    localparam int KEY_W     = 64;
    localparam int CMD_W     = 3;
    localparam int SLOT_W    = 3;
    localparam int POS_W     = 3;
    localparam int STS_W     = 3;
    localparam int CNT_OUT_W = 4;

    // Derived widths of the storage and its indexes.
    localparam int DIR_AW   = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
    localparam int FSLOT_AW = (FILES_PER_DIR > 1) ? $clog2(FILES_PER_DIR) : 1;
    localparam int FILE_AW  = (MAX_DIRS * FILES_PER_DIR > 1) ?
                              $clog2(MAX_DIRS * FILES_PER_DIR) : 1;
    localparam int DCNT_W   = $clog2(MAX_DIRS + 1);
    localparam int FCNT_W   = $clog2(FILES_PER_DIR + 1);
    localparam int SCAN_W   = (FCNT_W > DCNT_W) ? FCNT_W : DCNT_W;

    // Input tdata layout, lowest field first.
    localparam int S_CMD_LSB   = 0;
    localparam int S_DKEY_LSB  = S_CMD_LSB + CMD_W;
    localparam int S_FKEY_LSB  = S_DKEY_LSB + KEY_W;
    localparam int S_DSLOT_LSB = S_FKEY_LSB + KEY_W;
    localparam int S_FSLOT_LSB = S_DSLOT_LSB + SLOT_W;
    localparam int S_USED_W    = S_FSLOT_LSB + SLOT_W;
    localparam int S_DATA_W    = ((S_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest field first.
    localparam int M_USED_W = STS_W + 2 * POS_W + KEY_W + 2 * CNT_OUT_W;
    localparam int M_DATA_W = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_MKDIR  = 3'd0,
        CMD_MKFILE = 3'd1,
        CMD_RMFILE = 3'd2,
        CMD_FIND   = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 3'd0,
        STS_NO_DIR    = 3'd1,
        STS_NO_FILE   = 3'd2,
        STS_FULL      = 3'd3,
        STS_BAD_INDEX = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DSCAN,
        ST_FSCAN,
        ST_SHIFT,
        ST_READ,
        ST_DONE
    } state_t;

    // One finished result, before the directory count is added.
    typedef struct packed {
        status_t                status;
        logic [POS_W-1:0]       dpos;
        logic [POS_W-1:0]       fpos;
        logic [KEY_W-1:0]       name;
        logic [CNT_OUT_W-1:0]   files;
    } result_t;

    // Address of one file slot in the flat file-name memory.
    function automatic logic [FILE_AW-1:0] f_file_addr(input logic [DIR_AW-1:0]   d,
                                                       input logic [FSLOT_AW-1:0] i);
        return FILE_AW'(d) * FILE_AW'(FILES_PER_DIR) + FILE_AW'(i);
    endfunction

endpackage

`default_nettype wire

// ----- sv/two_level_name_directory_unit.sv -----
// Top level of the two-level name directory: directory and file tables with search.
//
//  Channel  Direction  Handshake                  Payload
//  s_       in         s_tvalid / s_tready        command, two keys, two slots
//  m_       out        m_tvalid / m_tready        status, positions, name, counts
//
// One command is in flight; a new one is taken once its result is in the output register.
// Create directory, bad index and unknown commands go straight to the result; a slot
// read first reads the name memories; create file scans the directories, search also
// scans the files, and delete shifts later files down; a full output register adds stalls.
// The scans read one entry a cycle through the single read port of each name memory.
// Reset clears the counts at once; the name memories need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "two_level_name_directory_unit_defines.svh"

module two_level_name_directory_unit #(
    parameter int NAME_BYTES = tlnd_pkg::DEF_NAME_BYTES
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // s_tdata: cmd, dir_key, file_key, dir_slot, file_slot (lowest bit up)
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [tlnd_pkg::S_DATA_W-1:0] s_tdata,
    // m_tdata: status, dir_position, file_position, name_read, files_in_dir,
    //          dirs_in_use (lowest bit up)
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tlnd_pkg::M_DATA_W-1:0]      m_tdata
);
    import tlnd_pkg::*;

    localparam int NAME_W = NAME_BYTES * 8;

    // Unpacked input fields; keys keep only the stored name bytes.
    cmd_t                in_cmd;
    logic [NAME_W-1:0]   in_dkey;
    logic [NAME_W-1:0]   in_fkey;
    logic [SLOT_W-1:0]   in_dslot;
    logic [SLOT_W-1:0]   in_fslot;

    assign in_cmd   = cmd_t'(s_tdata[S_CMD_LSB +: CMD_W]);
    assign in_dkey  = s_tdata[S_DKEY_LSB +: NAME_W];
    assign in_fkey  = s_tdata[S_FKEY_LSB +: NAME_W];
    assign in_dslot = s_tdata[S_DSLOT_LSB +: SLOT_W];
    assign in_fslot = s_tdata[S_FSLOT_LSB +: SLOT_W];

    // Control and command registers.
    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [NAME_W-1:0]   dkey_reg, dkey_next;
    logic [NAME_W-1:0]   fkey_reg, fkey_next;
    logic [DIR_AW-1:0]   dslot_reg, dslot_next;
    logic [SLOT_W-1:0]   fslot_reg, fslot_next;
    logic [DIR_AW-1:0]   dpos_reg, dpos_next;
    logic [SCAN_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [SCAN_W-1:0]   scan_lim_reg, scan_lim_next;
    logic                pend_reg, pend_next;
    logic [SCAN_W-1:0]   pend_idx_reg, pend_idx_next;
    result_t             res_reg, res_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Counts, cleared by reset.
    logic [FCNT_W-1:0]   file_cnt_reg [MAX_DIRS];
    logic [DCNT_W-1:0]   dir_total_reg, dir_total_next;

    // Name memories.
    logic [NAME_W-1:0]   dir_mem  [MAX_DIRS];
    logic [NAME_W-1:0]   file_mem [MAX_DIRS * FILES_PER_DIR];
    logic [NAME_W-1:0]   dir_rdata_reg;
    logic [NAME_W-1:0]   file_rdata_reg;

    // Memory and count access controls.
    logic                dir_we;
    logic [DIR_AW-1:0]   dir_waddr;
    logic [NAME_W-1:0]   dir_wdata;
    logic [DIR_AW-1:0]   dir_raddr;
    logic                file_we;
    logic [FILE_AW-1:0]  file_waddr;
    logic [NAME_W-1:0]   file_wdata;
    logic [FILE_AW-1:0]  file_raddr;
    logic                cnt_we;
    logic [DIR_AW-1:0]   cnt_waddr;
    logic [FCNT_W-1:0]   cnt_wdata;
    logic [DIR_AW-1:0]   cnt_raddr;
    logic [FCNT_W-1:0]   cnt_rdata;

    logic                issue;
    logic                hit;
    logic [SCAN_W-1:0]   shift_dst;

    assign cnt_rdata = file_cnt_reg[cnt_raddr];
    assign shift_dst = pend_idx_reg - SCAN_W'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Directory-name memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (dir_we) begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        dir_rdata_reg <= dir_mem[dir_raddr];
    end

    // File-name memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (file_we) begin
            file_mem[file_waddr] <= file_wdata;
        end
        file_rdata_reg <= file_mem[file_raddr];
    end

    // Per-directory file counts and the directory count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DIRS; i++) begin
                file_cnt_reg[i] <= '0;
            end
            dir_total_reg <= '0;
        end else begin
            if (cnt_we) begin
                file_cnt_reg[cnt_waddr] <= cnt_wdata;
            end
            dir_total_reg <= dir_total_next;
        end
    end

    // Control state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        dkey_reg     <= dkey_next;
        fkey_reg     <= fkey_next;
        dslot_reg    <= dslot_next;
        fslot_reg    <= fslot_next;
        dpos_reg     <= dpos_next;
        scan_idx_reg <= scan_idx_next;
        scan_lim_reg <= scan_lim_next;
        pend_idx_reg <= pend_idx_next;
        res_reg      <= res_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // Command sequencer: scans, updates and result hand-off.
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        dkey_next      = dkey_reg;
        fkey_next      = fkey_reg;
        dslot_next     = dslot_reg;
        fslot_next     = fslot_reg;
        dpos_next      = dpos_reg;
        scan_idx_next  = scan_idx_reg;
        scan_lim_next  = scan_lim_reg;
        pend_next      = 1'b0;
        pend_idx_next  = scan_idx_reg;
        res_next       = res_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        dir_total_next = dir_total_reg;

        dir_we     = 1'b0;
        dir_waddr  = dir_total_reg[DIR_AW-1:0];
        dir_wdata  = in_dkey;
        dir_raddr  = scan_idx_reg[DIR_AW-1:0];
        file_we    = 1'b0;
        file_waddr = f_file_addr(dpos_reg, shift_dst[FSLOT_AW-1:0]);
        file_wdata = file_rdata_reg;
        file_raddr = f_file_addr(dpos_reg, scan_idx_reg[FSLOT_AW-1:0]);
        cnt_we     = 1'b0;
        cnt_waddr  = dpos_reg;
        cnt_wdata  = '0;
        cnt_raddr  = dpos_reg;

        issue = (scan_idx_reg < scan_lim_reg);
        hit   = 1'b0;

        // The output register empties when its transaction completes.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                // Slot reads are issued here so the data is ready next cycle.
                dir_raddr  = DIR_AW'(in_dslot);
                cnt_raddr  = DIR_AW'(in_dslot);
                file_raddr = f_file_addr(DIR_AW'(in_dslot), FSLOT_AW'(in_fslot));
                if (s_tvalid) begin
                    cmd_next      = in_cmd;
                    dkey_next     = in_dkey;
                    fkey_next     = in_fkey;
                    dslot_next    = DIR_AW'(in_dslot);
                    fslot_next    = in_fslot;
                    scan_idx_next = '0;
                    scan_lim_next = SCAN_W'(dir_total_reg);
                    res_next      = '0;
                    unique case (in_cmd)
                        CMD_MKDIR: begin
                            if (dir_total_reg >= DCNT_W'(MAX_DIRS)) begin
                                res_next.status = STS_FULL;
                            end else begin
                                dir_we         = 1'b1;
                                cnt_we         = 1'b1;
                                cnt_waddr      = dir_total_reg[DIR_AW-1:0];
                                dir_total_next = dir_total_reg + DCNT_W'(1);
                                res_next.dpos  = POS_W'(dir_total_reg);
                            end
                            state_next = ST_DONE;
                        end
                        CMD_MKFILE, CMD_RMFILE, CMD_FIND: begin
                            state_next = ST_DSCAN;
                        end
                        CMD_READ: begin
                            if (DCNT_W'(in_dslot) >= dir_total_reg) begin
                                res_next.status = STS_BAD_INDEX;
                                state_next      = ST_DONE;
                            end else begin
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                            res_next.status = STS_BAD_INDEX;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end

            ST_DSCAN: begin
                // One directory name read per cycle, compared once it is in the read register.
                pend_next = issue;
                if (issue) begin
                    scan_idx_next = scan_idx_reg + SCAN_W'(1);
                end
                cnt_raddr = pend_idx_reg[DIR_AW-1:0];
                hit       = pend_reg && (dir_rdata_reg == dkey_reg);
                if (hit) begin
                    dpos_next     = pend_idx_reg[DIR_AW-1:0];
                    res_next.dpos = POS_W'(pend_idx_reg);
                    if (cmd_reg == CMD_MKFILE) begin
                        res_next.files = CNT_OUT_W'(cnt_rdata);
                        if (cnt_rdata >= FCNT_W'(FILES_PER_DIR)) begin
                            res_next.status = STS_FULL;
                        end else begin
                            file_we    = 1'b1;
                            file_waddr = f_file_addr(pend_idx_reg[DIR_AW-1:0],
                                                     cnt_rdata[FSLOT_AW-1:0]);
                            file_wdata = fkey_reg;
                            cnt_we     = 1'b1;
                            cnt_waddr  = pend_idx_reg[DIR_AW-1:0];
                            cnt_wdata  = cnt_rdata + FCNT_W'(1);
                            res_next.fpos  = POS_W'(cnt_rdata);
                            res_next.files = CNT_OUT_W'(cnt_wdata);
                        end
                        state_next = ST_DONE;
                    end else begin
                        scan_idx_next = '0;
                        scan_lim_next = SCAN_W'(cnt_rdata);
                        pend_next     = 1'b0;
                        state_next    = ST_FSCAN;
                    end
                end else if (!issue && !pend_reg) begin
                    res_next.status = STS_NO_DIR;
                    state_next      = ST_DONE;
                end
            end

            ST_FSCAN: begin
                // One file name read per cycle within the found directory.
                pend_next = issue;
                if (issue) begin
                    scan_idx_next = scan_idx_reg + SCAN_W'(1);
                end
                hit = pend_reg && (file_rdata_reg == fkey_reg);
                res_next.files = CNT_OUT_W'(cnt_rdata);
                if (hit) begin
                    res_next.fpos = POS_W'(pend_idx_reg);
                    if (cmd_reg == CMD_RMFILE) begin
                        cnt_we         = 1'b1;
                        cnt_wdata      = cnt_rdata - FCNT_W'(1);
                        res_next.files = CNT_OUT_W'(cnt_wdata);
                        scan_idx_next  = pend_idx_reg + SCAN_W'(1);
                        pend_next      = 1'b0;
                        state_next     = ST_SHIFT;
                    end else begin
                        state_next = ST_DONE;
                    end
                end else if (!issue && !pend_reg) begin
                    res_next.status = STS_NO_FILE;
                    state_next      = ST_DONE;
                end
            end

            ST_SHIFT: begin
                // Read slot i and write it back to slot i - 1 from the read register.
                pend_next = issue;
                if (issue) begin
                    scan_idx_next = scan_idx_reg + SCAN_W'(1);
                end
                file_we = pend_reg;
                if (!issue && !pend_reg) begin
                    state_next = ST_DONE;
                end
            end

            ST_READ: begin
                // The names addressed at accept time are now in the read registers.
                cnt_raddr      = dslot_reg;
                res_next.dpos  = POS_W'(dslot_reg);
                res_next.fpos  = POS_W'(fslot_reg);
                res_next.files = CNT_OUT_W'(cnt_rdata);
                if (FCNT_W'(fslot_reg) < cnt_rdata) begin
                    res_next.name = KEY_W'(file_rdata_reg);
                end else begin
                    res_next.name = KEY_W'(dir_rdata_reg);
                end
                state_next = ST_DONE;
            end

            ST_DONE: begin
                // Move the result into the output register once it is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({CNT_OUT_W'(dir_total_reg), res_reg.files,
                                               res_reg.name, res_reg.fpos, res_reg.dpos,
                                               res_reg.status});
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Checks on the sequencer and the tables.
    `TLND_ASSERT_ALWAYS(a_dir_total_bound, dir_total_reg <= DCNT_W'(MAX_DIRS),
                        "directory count overflow")
    `TLND_ASSERT_ALWAYS(a_file_cnt_bound, cnt_rdata <= FCNT_W'(FILES_PER_DIR),
                        "file count overflow")
    `TLND_ASSERT_IMP(a_shift_no_overlap, file_we && (state_reg == ST_SHIFT),
                     file_waddr != file_raddr, "shift reads the slot it writes")
    `TLND_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready,
                     "second command taken while busy")

endmodule

`default_nettype wire
